// ===== rtl/sei_pkg.sv =====
// Shared types and constants for the SEI message builder.
// Holds the request structs, the job queue entry, the back-end state
// encoding and the fixed bytes of the packet header. No dependencies.
package sei_pkg;

	localparam int unsigned MAX_CONTENT = 1024;
	localparam int unsigned LEN_W = 11;
	localparam int unsigned UUID_BYTES = 16;

	localparam logic [7:0] START_CODE_ZERO = 8'h00;
	localparam logic [7:0] START_CODE_LAST = 8'h01;
	localparam logic [7:0] NAL_H264 = 8'h06;
	localparam logic [7:0] NAL_H265_TYPE = 8'(39 << 1);
	localparam logic [7:0] NAL_H265_TAIL = 8'h01;
	localparam logic [7:0] PAYLOAD_TYPE = 8'h05;
	localparam logic [7:0] SIZE_FILL = 8'hFF;
	localparam logic [7:0] TRAIL_BYTE = 8'h80;
	localparam logic [LEN_W-1:0] SIZE_STEP = LEN_W'(255);
	localparam logic [LEN_W-1:0] UUID_LEN = LEN_W'(UUID_BYTES);

	typedef enum logic {
		CMD_START = 1'b0,
		CMD_CONTENT = 1'b1
	} command_t;

	typedef enum logic [1:0] {
		CFG_CODEC_MODE = 2'd0,
		CFG_UUID_HIGH = 2'd1,
		CFG_UUID_LOW = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic command;
		logic [10:0] content_length;
		logic [7:0] content_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic run_last;
		logic packet_end;
	} out_item_t;

	typedef enum logic {
		JOB_START = 1'b0,
		JOB_CONTENT = 1'b1
	} job_kind_t;

	typedef struct packed {
		job_kind_t kind;
		logic [LEN_W-1:0] arg;
		logic last;
	} job_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_SC,
		B_NAL0,
		B_NAL1,
		B_PTYPE,
		B_SIZE,
		B_UUID,
		B_END
	} back_state_t;

endpackage

// ===== rtl/sei_front.sv =====
// Front end of the SEI message builder: accepts requests, tracks the open
// message and turns each request into a job for the back end, or drops it.
// Depends on sei_pkg.
module sei_front import sei_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_data,
	input  logic     job_full,
	output logic     job_push,
	output job_t     job
);

	logic in_message_q;
	logic [LEN_W-1:0] bytes_left_q;
	logic accept;
	logic [LEN_W-1:0] len_sat;

	assign in_ready = !job_full;
	assign accept = in_valid && in_ready;
	assign len_sat = (in_data.content_length > LEN_W'(MAX_CONTENT)) ?
		LEN_W'(MAX_CONTENT) : in_data.content_length;

	always_comb begin
		job_push = 1'b0;
		job.kind = JOB_START;
		job.arg = len_sat;
		job.last = 1'b0;
		if (accept) begin
			if (in_data.command == CMD_START) begin
				job_push = 1'b1;
			end else if (in_message_q && bytes_left_q != '0) begin
				job_push = 1'b1;
				job.kind = JOB_CONTENT;
				job.arg = LEN_W'(in_data.content_byte);
				job.last = (bytes_left_q == LEN_W'(1));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_message_q <= 1'b0;
			bytes_left_q <= '0;
		end else if (accept) begin
			if (in_data.command == CMD_START) begin
				in_message_q <= (len_sat != '0);
				bytes_left_q <= len_sat;
			end else if (in_message_q && bytes_left_q != '0) begin
				bytes_left_q <= bytes_left_q - LEN_W'(1);
				in_message_q <= (bytes_left_q != LEN_W'(1));
			end
		end
	end

endmodule

// ===== rtl/sei_job_fifo.sv =====
// Two-entry job queue between the front and back ends of the SEI builder.
// Depends on sei_pkg.
module sei_job_fifo import sei_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_data,
	output logic full,
	input  logic pop,
	output job_t pop_data,
	output logic not_empty
);

	job_t entry_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;

	assign full = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/sei_back.sv =====
// Back end of the SEI builder: a byte sequencer that expands each job into
// packet bytes and holds them in an output register. Depends on sei_pkg.
module sei_back import sei_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         job_valid,
	input  job_t         job,
	output logic         job_pop,
	input  logic         codec_mode,
	input  logic [127:0] uuid,
	output logic         out_valid,
	input  logic         out_ready,
	output out_item_t    out_data
);

	back_state_t state_q, state_d;
	logic [3:0] cnt_q, cnt_d;
	logic [LEN_W-1:0] remain_q, remain_d;
	logic empty_q, empty_d;
	logic out_valid_q;
	out_item_t out_data_q;
	logic advance;
	logic load;
	out_item_t nb;

	assign advance = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		remain_d = remain_q;
		empty_d = empty_q;
		job_pop = 1'b0;
		load = 1'b0;
		nb.out_byte = START_CODE_ZERO;
		nb.run_last = 1'b0;
		nb.packet_end = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (advance && job_valid) begin
					job_pop = 1'b1;
					load = 1'b1;
					if (job.kind == JOB_CONTENT) begin
						nb.out_byte = job.arg[7:0];
						nb.run_last = !job.last;
						if (job.last) begin
							state_d = B_END;
						end
					end else begin
						state_d = B_SC;
						cnt_d = 4'd1;
						remain_d = job.arg + UUID_LEN;
						empty_d = (job.arg == '0);
					end
				end
			end
			B_SC: begin
				if (advance) begin
					load = 1'b1;
					if (cnt_q == 4'd3) begin
						nb.out_byte = START_CODE_LAST;
						state_d = B_NAL0;
					end else begin
						cnt_d = cnt_q + 4'd1;
					end
				end
			end
			B_NAL0: begin
				if (advance) begin
					load = 1'b1;
					nb.out_byte = codec_mode ? NAL_H265_TYPE : NAL_H264;
					state_d = codec_mode ? B_NAL1 : B_PTYPE;
				end
			end
			B_NAL1: begin
				if (advance) begin
					load = 1'b1;
					nb.out_byte = NAL_H265_TAIL;
					state_d = B_PTYPE;
				end
			end
			B_PTYPE: begin
				if (advance) begin
					load = 1'b1;
					nb.out_byte = PAYLOAD_TYPE;
					state_d = B_SIZE;
				end
			end
			B_SIZE: begin
				if (advance) begin
					load = 1'b1;
					if (remain_q >= SIZE_STEP) begin
						nb.out_byte = SIZE_FILL;
						remain_d = remain_q - SIZE_STEP;
					end else begin
						nb.out_byte = remain_q[7:0];
						state_d = B_UUID;
						cnt_d = 4'd0;
					end
				end
			end
			B_UUID: begin
				if (advance) begin
					load = 1'b1;
					nb.out_byte = uuid[{~cnt_q, 3'b000} +: 8];
					cnt_d = cnt_q + 4'd1;
					if (cnt_q == 4'd15) begin
						nb.run_last = !empty_q;
						state_d = empty_q ? B_END : B_IDLE;
					end
				end
			end
			B_END: begin
				if (advance) begin
					load = 1'b1;
					nb.out_byte = TRAIL_BYTE;
					nb.run_last = 1'b1;
					nb.packet_end = 1'b1;
					state_d = B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			cnt_q <= 4'd0;
			remain_q <= '0;
			empty_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			remain_q <= remain_d;
			empty_q <= empty_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_data_q <= nb;
		end
	end

	a_end_marks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_q.packet_end |->
		out_data_q.run_last && out_data_q.out_byte == TRAIL_BYTE)
		else $error("Packet end is not a final trailing byte.");

	a_size_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_SIZE |-> remain_q <= LEN_W'(MAX_CONTENT + UUID_BYTES))
		else $error("Payload size count out of range.");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> state_q == B_IDLE && job_valid && advance)
		else $error("Job taken while the sequencer is busy.");

endmodule

// ===== rtl/sei_message_builder.sv =====
// Top level of the SEI message builder: configuration registers, front end,
// job queue and byte sequencer. Depends on sei_pkg and the sei_* modules.
// A content request yields its byte and streams at one request per clock
// unless the output stalls or the sequencer is busy; the final
// content byte is followed by the trailing 0x80. A start request keeps the
// sequencer busy for its header (6 or 7 fixed bytes, 1 to 5 size bytes, 16
// UUID bytes, and the trailing byte for an empty message). A two-entry job
// queue lets the input side take requests while the sequencer still emits a header.
// Configuration writes take effect at once and must only occur while idle.
module sei_message_builder import sei_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [63:0] wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_data
);

	logic codec_mode_q;
	logic [63:0] uuid_high_q;
	logic [63:0] uuid_low_q;
	logic job_full;
	logic job_push;
	job_t job_in;
	logic job_pop;
	job_t job_out;
	logic job_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codec_mode_q <= 1'b0;
			uuid_high_q <= 64'h5480_8397_F023_474B;
			uuid_low_q <= 64'hB7F7_4F32_B54E_06AC;
		end else if (wr_en) begin
			case (wr_index)
				CFG_CODEC_MODE: codec_mode_q <= wr_data[0];
				CFG_UUID_HIGH: uuid_high_q <= wr_data;
				CFG_UUID_LOW: uuid_low_q <= wr_data;
				default: codec_mode_q <= codec_mode_q;
			endcase
		end
	end

	sei_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.job_full (job_full),
		.job_push (job_push),
		.job      (job_in)
	);

	sei_job_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.push_data (job_in),
		.full      (job_full),
		.pop       (job_pop),
		.pop_data  (job_out),
		.not_empty (job_valid)
	);

	sei_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (job_valid),
		.job        (job_out),
		.job_pop    (job_pop),
		.codec_mode (codec_mode_q),
		.uuid       ({uuid_high_q, uuid_low_q}),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule

// ===== verif/sei_message_builder_test.sv =====
// Self-checking testbench for sei_message_builder: drives start and content requests,
// predicts every emitted SEI byte and compares results in order of arrival.
// Depends on sei_pkg and the RTL of sei_message_builder.
`timescale 1ns / 100ps

module sei_message_builder_test import sei_pkg::*;;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES = 250;
	localparam int RANDOM_PHASES = 4;
	localparam int PHASE_REQUESTS = 92;
	localparam logic [1:0] CFG_UNUSED = 2'd3;
	localparam logic [63:0] UUID_HIGH_RESET = 64'h54808397F023474B;
	localparam logic [63:0] UUID_LOW_RESET = 64'hB7F74F32B54E06AC;

	logic clk = 1'b0;
	logic arst_n;
	logic wr_en;
	logic [1:0] wr_index;
	logic [63:0] wr_data;
	logic in_valid;
	logic in_ready;
	in_item_t in_data;
	logic out_valid;
	logic out_ready = 1'b1;
	out_item_t out_data;

	// Predictor state: open message, content bytes still due, and register copies.
	logic msg_open;
	logic [10:0] bytes_to_go;
	logic codec_h265;
	logic [63:0] uuid_hi;
	logic [63:0] uuid_lo;
	out_item_t staged[$];
	out_item_t expected_bytes[$];

	bit sender_gaps_on;
	bit receiver_stalls_on;
	bit hold_off_req;
	int errors;
	int cycle_count;
	int accepted_requests;
	int productive_requests;
	int checked_bytes;
	int closed_packets;
	int config_phases;

	sei_message_builder dut (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d bytes outstanding", $time, expected_bytes.size());
			$display("FAILURE");
			$finish;
		end
	end

	function automatic void stage(input logic [7:0] value, input logic closing);
		out_item_t o;
		o.out_byte = value;
		o.run_last = 1'b0;
		o.packet_end = closing;
		staged.push_back(o);
	endfunction

	function automatic int predict_request(input in_item_t req);
		logic [10:0] len;
		int remaining;
		int n;
		out_item_t o;
		if (req.command == CMD_START) begin
			len = req.content_length;
			if (len > 11'(MAX_CONTENT)) begin
				len = 11'(MAX_CONTENT);
			end
			stage(8'h00, 1'b0);
			stage(8'h00, 1'b0);
			stage(8'h00, 1'b0);
			stage(8'h01, 1'b0);
			if (codec_h265) begin
				stage(8'h4E, 1'b0);
				stage(8'h01, 1'b0);
			end else begin
				stage(8'h06, 1'b0);
			end
			stage(8'h05, 1'b0);
			remaining = int'(len) + 16;
			while (remaining >= 255) begin
				stage(8'hFF, 1'b0);
				remaining -= 255;
			end
			stage(8'(remaining), 1'b0);
			for (int i = 7; i >= 0; i--) begin
				stage(uuid_hi[i*8 +: 8], 1'b0);
			end
			for (int i = 7; i >= 0; i--) begin
				stage(uuid_lo[i*8 +: 8], 1'b0);
			end
			if (len == 0) begin
				stage(8'h80, 1'b1);
				msg_open = 1'b0;
				bytes_to_go = '0;
			end else begin
				msg_open = 1'b1;
				bytes_to_go = len;
			end
		end else if (msg_open && bytes_to_go != 0) begin
			stage(req.content_byte, 1'b0);
			bytes_to_go = bytes_to_go - 11'd1;
			if (bytes_to_go == 0) begin
				stage(8'h80, 1'b1);
				msg_open = 1'b0;
			end
		end
		n = staged.size();
		for (int i = 0; i < n; i++) begin
			o = staged[i];
			o.run_last = (i == n - 1);
			expected_bytes.push_back(o);
		end
		staged.delete();
		return n;
	endfunction

	function automatic in_item_t start_req(input logic [10:0] len);
		in_item_t r;
		r.command = CMD_START;
		r.content_length = len;
		r.content_byte = 8'($urandom);
		return r;
	endfunction

	function automatic in_item_t content_req(input logic [7:0] value);
		in_item_t r;
		r.command = CMD_CONTENT;
		r.content_length = 11'($urandom);
		r.content_byte = value;
		return r;
	endfunction

	task automatic send_request(input in_item_t req);
		int gap;
		if (sender_gaps_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			gap = $urandom_range(1, 14);
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= req;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		accepted_requests++;
		if (predict_request(req) > 0) begin
			productive_requests++;
		end
	endtask

	// The sender stops and waits until every predicted byte has been checked.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		@(posedge clk);
		wr_en <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_CODEC_MODE: codec_h265 = value[0];
			CFG_UUID_HIGH: uuid_hi = value;
			CFG_UUID_LOW: uuid_lo = value;
			default: ;
		endcase
	endtask

	task automatic set_config(input logic codec, input logic [63:0] hi, input logic [63:0] lo);
		write_reg(CFG_CODEC_MODE, {63'($urandom), codec});
		write_reg(CFG_UUID_HIGH, hi);
		write_reg(CFG_UUID_LOW, lo);
		config_phases++;
	endtask

	task automatic set_random_config();
		set_config(1'($urandom), {$urandom, $urandom}, {$urandom, $urandom});
	endtask

	always @(posedge clk) begin : byte_checker
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_bytes.size() == 0) begin
				$display("%0t: unexpected byte, actual %h run_last %b packet_end %b", $time,
					out_data.out_byte, out_data.run_last, out_data.packet_end);
				errors++;
			end else begin
				want = expected_bytes.pop_front();
				checked_bytes++;
				if (want.packet_end) begin
					closed_packets++;
				end
				if (out_data.out_byte !== want.out_byte) begin
					$display("%0t: out_byte mismatch, expected %h actual %h", $time,
						want.out_byte, out_data.out_byte);
					errors++;
				end
				if (out_data.run_last !== want.run_last) begin
					$display("%0t: run_last mismatch, expected %b actual %b", $time,
						want.run_last, out_data.run_last);
					errors++;
				end
				if (out_data.packet_end !== want.packet_end) begin
					$display("%0t: packet_end mismatch, expected %b actual %b", $time,
						want.packet_end, out_data.packet_end);
					errors++;
				end
			end
		end
	end

	always begin : ready_driver
		int held;
		int burst;
		@(posedge clk);
		if (hold_off_req) begin
			out_ready <= 1'b0;
			for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
			out_ready <= 1'b1;
			hold_off_req = 1'b0;
		end else if (receiver_stalls_on && $urandom_range(0, 9) == 0) begin
			out_ready <= 1'b0;
			burst = $urandom_range(1, 14);
			repeat (burst) @(posedge clk);
			out_ready <= 1'b1;
		end
	end

	task automatic test_short_messages();
		send_request(content_req(8'h3C));
		send_request(start_req(11'd0));
		send_request(start_req(11'd3));
		send_request(content_req(8'h00));
		send_request(content_req(8'hFF));
		send_request(content_req(8'h5A));
		send_request(content_req(8'hC3));
		settle();
	endtask

	task automatic test_size_field();
		set_config(1'b1, '1, '0);
		send_request(start_req(11'd238));
		send_request(start_req(11'd239));
		send_request(start_req(11'd1024));
		send_request(start_req(11'd2047));
		send_request(start_req(11'd1));
		send_request(content_req(8'hA5));
		send_request(content_req(8'h81));
		settle();
	endtask

	task automatic test_restart_in_message();
		set_config(1'b0, '0, '1);
		write_reg(CFG_UNUSED, {$urandom, $urandom});
		send_request(start_req(11'd5));
		send_request(content_req(8'h11));
		send_request(content_req(8'hEE));
		send_request(start_req(11'd2));
		send_request(content_req(8'h80));
		send_request(content_req(8'h7F));
		settle();
	endtask

	// The receiver holds off long enough for the block to fill and stall its input.
	task automatic test_output_hold_off();
		set_random_config();
		sender_gaps_on = 1'b0;
		hold_off_req = 1'b1;
		send_request(start_req(11'd60));
		for (int i = 0; i < 60; i++) begin
			send_request(content_req(8'($urandom)));
		end
		settle();
	endtask

	task automatic test_random_traffic();
		int goal;
		int len;
		int body;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p == 0) begin
				set_config(1'b1, '1, '1);
			end else begin
				set_random_config();
			end
			receiver_stalls_on = (p != RANDOM_PHASES - 1);
			goal = accepted_requests + PHASE_REQUESTS;
			while (accepted_requests < goal) begin
				sender_gaps_on = (p != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
				if ($urandom_range(0, 99) < 6) begin
					send_request(content_req(8'($urandom)));
				end else begin
					case ($urandom_range(0, 49))
						0: len = $urandom_range(1025, 2047);
						1, 2: len = $urandom_range(200, 300);
						3, 4, 5, 6, 7, 8, 9: len = $urandom_range(9, 40);
						default: len = $urandom_range(0, 8);
					endcase
					send_request(start_req(11'(len)));
					body = (len > MAX_CONTENT) ? $urandom_range(0, 6) : len;
					if (body > goal - accepted_requests) begin
						body = goal - accepted_requests;
					end
					if (body > 0 && $urandom_range(0, 9) == 0) begin
						body = $urandom_range(0, body - 1);
					end
					for (int i = 0; i < body; i++) begin
						send_request(content_req(8'($urandom)));
					end
					if ($urandom_range(0, 7) == 0) begin
						send_request(content_req(8'($urandom)));
					end
				end
			end
			settle();
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		wr_en <= 1'b0;
		wr_index <= CFG_CODEC_MODE;
		wr_data <= '0;
		in_valid <= 1'b0;
		in_data <= '0;
		msg_open = 1'b0;
		bytes_to_go = '0;
		codec_h265 = 1'b0;
		uuid_hi = UUID_HIGH_RESET;
		uuid_lo = UUID_LOW_RESET;
		sender_gaps_on = 1'b1;
		receiver_stalls_on = 1'b1;
		hold_off_req = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_short_messages();
		test_size_field();
		test_restart_in_message();
		test_output_hold_off();
		test_random_traffic();
		$display("Ran %0d requests (%0d emitting bytes), checked %0d bytes in %0d closed packets.",
			accepted_requests, productive_requests, checked_bytes, closed_packets);
		$display("Used %0d register settings, both NAL header forms and a long output hold-off.",
			config_phases + 1);
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
